@@ sv/sfir_pkg.sv @@
`timescale 1ns / 1ps

package sfir_pkg;

  localparam int DEFAULT_TAPS = 256;
  localparam int SMP_W        = 32;
  localparam int ACC_W        = 64;
  localparam int SHIFT_W      = 6;

  localparam logic [SHIFT_W-1:0] FRAC_BITS_RESET = 6'd31;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // travels with each tap from the memory read through the MAC
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctrl_t;

  function automatic logic signed [ACC_W-1:0] sat_add64(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W-1:0] sum;
    sum = a + b;
    if ((a[ACC_W-1] == b[ACC_W-1]) && (sum[ACC_W-1] != a[ACC_W-1])) begin
      sum = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return sum;
  endfunction

  function automatic logic signed [SMP_W-1:0] asr_sat32(
    input logic signed [ACC_W-1:0] x,
    input logic [SHIFT_W-1:0]      sh
  );
    logic signed [ACC_W-1:0] s;
    logic signed [SMP_W-1:0] res;
    s = x >>> sh;
    if ((&s[ACC_W-1:SMP_W-1]) || !(|s[ACC_W-1:SMP_W-1])) begin
      res = s[SMP_W-1:0];
    end else begin
      res = s[ACC_W-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

@@ sv/sfir_mac.sv @@
`timescale 1ns / 1ps

module sfir_mac
  import sfir_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  mac_ctrl_t               ctrl,
  input  logic signed [SMP_W-1:0] left_smp,
  input  logic signed [SMP_W-1:0] right_smp,
  input  logic signed [SMP_W-1:0] coef,
  output logic signed [ACC_W-1:0] acc_left,
  output logic signed [ACC_W-1:0] acc_right,
  output logic                    done
);

  mac_ctrl_t               ctrl1_r;
  logic signed [ACC_W-1:0] prod_l_r;
  logic signed [ACC_W-1:0] prod_r_r;
  logic signed [ACC_W-1:0] acc_l_r;
  logic signed [ACC_W-1:0] acc_r_r;
  logic                    done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl1_r <= '0;
      done_r  <= 1'b0;
    end else begin
      ctrl1_r <= ctrl;
      done_r  <= ctrl1_r.vld && ctrl1_r.last;
    end
  end

  always_ff @(posedge clk) begin
    prod_l_r <= ACC_W'(left_smp) * ACC_W'(coef);
    prod_r_r <= ACC_W'(right_smp) * ACC_W'(coef);
    if (ctrl1_r.vld) begin
      // restart on the newest tap, saturate on every later one
      acc_l_r <= ctrl1_r.first ? prod_l_r : sat_add64(acc_l_r, prod_l_r);
      acc_r_r <= ctrl1_r.first ? prod_r_r : sat_add64(acc_r_r, prod_r_r);
    end
  end

  assign acc_left  = acc_l_r;
  assign acc_right = acc_r_r;
  assign done      = done_r;

endmodule

@@ sv/stereo_fir_filter_q31.sv @@
`timescale 1ns / 1ps

// Channel | Ports                                          | Transaction
// --------+------------------------------------------------+----------------------------------
// in      | in_valid/in_ready, in_op, in_coef_*, in_*_in   | one sample pair or one coefficient
// out     | out_valid/out_ready, out_left_out, out_right_out | one filtered sample pair
// cfg     | cfg_valid/cfg_ready, cfg_coef_frac_bits        | one write of the fraction shift
//
// A coefficient write is taken in the idle state. A sample runs one
// history/coefficient memory read per tap, then multiply, accumulate and
// output register stages. Reset clears control state; history entries not yet
// written since reset read as zero through a fill count, no clearing pass.
// A finished result waits in the output register; the block accepts the next
// transaction meanwhile and stalls only when a second result is ready first.

module stereo_fir_filter_q31
  import sfir_pkg::*;
#(
  parameter int TAPS = DEFAULT_TAPS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_op,
  input  logic [7:0]              in_coef_index,
  input  logic signed [SMP_W-1:0] in_coef_value,
  input  logic signed [SMP_W-1:0] in_left_in,
  input  logic signed [SMP_W-1:0] in_right_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SMP_W-1:0] out_left_out,
  output logic signed [SMP_W-1:0] out_right_out,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [SHIFT_W-1:0]      cfg_coef_frac_bits
);

  localparam int AW = $clog2(TAPS);
  localparam int FW = $clog2(TAPS + 1);
  localparam logic [AW-1:0] LAST_POS = AW'(TAPS - 1);
  localparam logic [FW-1:0] FULL_CNT = FW'(TAPS);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_FINISH} state_t;

  state_t                  state_r;
  logic [SHIFT_W-1:0]      frac_bits_r;
  logic [AW-1:0]           wp_r;
  logic [FW-1:0]           fill_r;
  logic [AW-1:0]           tap_r;
  logic [AW-1:0]           rd_pos_r;
  logic                    out_valid_r;
  logic signed [SMP_W-1:0] out_left_r;
  logic signed [SMP_W-1:0] out_right_r;

  logic [2*SMP_W-1:0]      hist_mem [TAPS];
  logic [SMP_W-1:0]        coef_mem [TAPS];
  logic [2*SMP_W-1:0]      hist_rd_r;
  logic [SMP_W-1:0]        coef_rd_r;
  logic                    hist_zero_r;
  mac_ctrl_t               ctrl0_r;

  logic                    in_acc;
  logic                    smp_acc;
  logic                    coef_wr;
  logic                    rd_issue;
  logic                    finish_go;
  logic signed [SMP_W-1:0] mac_left;
  logic signed [SMP_W-1:0] mac_right;
  logic signed [ACC_W-1:0] acc_left;
  logic signed [ACC_W-1:0] acc_right;
  logic                    mac_done;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign smp_acc   = in_acc && (in_op == OP_SAMPLE);
  assign coef_wr   = in_acc && (in_op == OP_COEF) && (32'(in_coef_index) < TAPS);
  assign rd_issue  = (state_r == ST_RUN);
  assign finish_go = (state_r == ST_FINISH) && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_bits_r <= FRAC_BITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frac_bits_r <= cfg_coef_frac_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_acc) begin
      hist_mem[wp_r] <= {in_left_in, in_right_in};
    end
    if (rd_issue) begin
      hist_rd_r <= hist_mem[rd_pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (coef_wr) begin
      coef_mem[AW'(in_coef_index)] <= in_coef_value;
    end
    if (rd_issue) begin
      coef_rd_r <= coef_mem[tap_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl0_r <= '0;
    end else begin
      ctrl0_r.vld   <= rd_issue;
      ctrl0_r.first <= (tap_r == LAST_POS);
      ctrl0_r.last  <= (tap_r == '0);
    end
    // entries past the fill count were never written since reset
    hist_zero_r <= (FW'(rd_pos_r) >= fill_r);
  end

  assign mac_left  = hist_zero_r ? '0 : hist_rd_r[2*SMP_W-1:SMP_W];
  assign mac_right = hist_zero_r ? '0 : hist_rd_r[SMP_W-1:0];

  sfir_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl0_r),
    .left_smp  (mac_left),
    .right_smp (mac_right),
    .coef      (coef_rd_r),
    .acc_left  (acc_left),
    .acc_right (acc_right),
    .done      (mac_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      tap_r       <= '0;
      rd_pos_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (finish_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (smp_acc) begin
            rd_pos_r <= wp_r;
            tap_r    <= LAST_POS;
            wp_r     <= (wp_r == LAST_POS) ? '0 : wp_r + 1'b1;
            if (fill_r != FULL_CNT) begin
              fill_r <= fill_r + 1'b1;
            end
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          // walk from the newest sample back to the oldest
          rd_pos_r <= (rd_pos_r == '0) ? LAST_POS : rd_pos_r - 1'b1;
          tap_r    <= tap_r - 1'b1;
          if (tap_r == '0) begin
            state_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (mac_done) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // hold the sums until the output register is free
          if (finish_go) begin
            out_left_r  <= asr_sat32(acc_left, frac_bits_r);
            out_right_r <= asr_sat32(acc_right, frac_bits_r);
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill count beyond tap count");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == ST_WAIT)
    else $error("accumulator finished outside of the wait state");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
    else $error("result raised without a finished accumulation");

  a_read_pipe_sync: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl0_r.vld |-> $past(state_r) == ST_RUN)
    else $error("tap entered the MAC without a memory read");
`endif

endmodule
